// ===== rtl/core/spf_pkg.sv =====
package spf_pkg;

  localparam int COORD_BITS       = 11;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_SPANS        = 8;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_SCAN  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] span_y;
    logic [COORD_BITS-1:0] span_x_start;
    logic [COORD_BITS-1:0] span_x_end;
    logic                  span_valid;
    logic                  last;
    logic                  fill_done;
    logic                  vertex_full;
  } result_t;

  // Control for the sorting cell row
  typedef struct packed {
    logic clr;
    logic ins;
    logic shl;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_GET,
    ST_TEST,
    ST_XING,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/scanline_polygon_span_fill.sv =====
// Scanline polygon span fill. Pulse start with an item while busy is low.
// Add, clear and unused actions return their result word on the next cycle
// with strobe high; busy stays low. A scanline request walks the stored
// vertices through one vertex RAM read port, passes each edge that crosses
// the row through the bit-serial divider, sorts the crossings on the fly in a
// row of cells and then emits one span word per cycle. The receiver cannot
// stall: each result word is valid only in its strobe cycle.
module scanline_polygon_span_fill #(
  parameter int MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  spf_pkg::item_t   item,
  output logic             busy,
  output spf_pkg::result_t result,
  output logic             strobe
);

  localparam int CW    = spf_pkg::COORD_BITS;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SPK_W = $clog2(spf_pkg::MAX_SPANS + 1);

  spf_pkg::state_t state, state_next;

  logic [CNT_W-1:0] vertex_count;
  logic [CW-1:0]    lowest_y;
  logic [CW-1:0]    highest_y;
  logic [CW-1:0]    current_line;
  logic             fill_started;

  logic [IDX_W-1:0]  idx;
  logic              closing;
  logic [2*CW-1:0]   first;
  logic [2*CW-1:0]   prev;
  logic [2*CW-1:0]   ea;
  logic [2*CW-1:0]   eb;
  logic [CW-1:0]     line_y;
  logic              line_done;
  logic [CNT_W-1:0]  ncross;
  logic [SPK_W-1:0]  span_k;

  logic              accept;
  logic              full;
  logic [CW-1:0]     cl;
  logic              row_ok;
  logic [CW-1:0]     cl_inc;
  logic              hit;
  logic              more;
  logic              adv;
  logic              xstart;
  logic              xdone;
  logic [CW-1:0]     xval;
  logic              ram_we;
  logic [2*CW-1:0]   rdata;
  logic [CNT_W-1:0]  half;
  logic [SPK_W-1:0]  npairs;
  spf_pkg::cell_ctl_t ctl;
  spf_pkg::result_t  result_next;

  logic [CW-1:0] cell_val   [MAX_VERTICES];
  logic          cell_valid [MAX_VERTICES];
  logic          cell_gt    [MAX_VERTICES];

  assign busy   = (state != spf_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (vertex_count >= CNT_W'(MAX_VERTICES));

  // Row selection for a scanline request
  assign cl     = fill_started ? current_line :
                  ((lowest_y == '1) ? '1 : lowest_y + 1'b1);
  assign row_ok = (cl < highest_y);
  assign cl_inc = cl + 1'b1;

  // Half-open edge test against the current row
  assign hit = ((ea[CW-1:0] <= line_y) && (eb[CW-1:0] > line_y)) ||
               ((eb[CW-1:0] <= line_y) && (ea[CW-1:0] > line_y));
  assign more = (CNT_W'(idx) + CNT_W'(1)) < vertex_count;

  assign half   = ncross >> 1;
  assign npairs = (32'(half) > spf_pkg::MAX_SPANS) ? SPK_W'(spf_pkg::MAX_SPANS)
                                                    : SPK_W'(half);

  spf_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_VERTICES)
  ) u_vram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(vertex_count[IDX_W-1:0]),
    .wdata({item.vertex_x, item.vertex_y}),
    .raddr(idx),
    .rdata(rdata)
  );

  spf_xing u_xing (
    .clk   (clk),
    .rst   (rst),
    .start (xstart),
    .ax    (ea[2*CW-1:CW]),
    .ay    (ea[CW-1:0]),
    .bx    (eb[2*CW-1:CW]),
    .by    (eb[CW-1:0]),
    .line_y(line_y),
    .done  (xdone),
    .x     (xval)
  );

  // Sorting row: ascending, cell 0 holds the smallest crossing
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic [CW-1:0] lv;
    logic          lvd;
    logic          lg;
    logic [CW-1:0] fv;
    logic          fvd;
    if (k == 0) begin : g_head
      assign lv  = '0;
      assign lvd = 1'b0;
      assign lg  = 1'b0;
    end else begin : g_mid
      assign lv  = cell_val[k-1];
      assign lvd = cell_valid[k-1];
      assign lg  = cell_gt[k-1];
    end
    if (k + 2 < MAX_VERTICES) begin : g_far
      assign fv  = cell_val[k+2];
      assign fvd = cell_valid[k+2];
    end else begin : g_tail
      assign fv  = '0;
      assign fvd = 1'b0;
    end
    spf_cell #(.W(CW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_val   (xval),
      .left_val  (lv),
      .left_valid(lvd),
      .left_gt   (lg),
      .far_val   (fv),
      .far_valid (fvd),
      .val       (cell_val[k]),
      .valid     (cell_valid[k]),
      .gt        (cell_gt[k])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      spf_pkg::ST_IDLE: begin
        if (accept && item.action == spf_pkg::ACT_SCAN && row_ok &&
            vertex_count != '0) begin
          state_next = spf_pkg::ST_RD;
        end
      end
      spf_pkg::ST_RD: state_next = spf_pkg::ST_GET;
      spf_pkg::ST_GET: begin
        if (idx == '0 && vertex_count == CNT_W'(1)) begin
          state_next = spf_pkg::ST_EMIT;
        end else if (idx == '0) begin
          state_next = spf_pkg::ST_RD;
        end else begin
          state_next = spf_pkg::ST_TEST;
        end
      end
      spf_pkg::ST_TEST, spf_pkg::ST_XING: begin
        if (state == spf_pkg::ST_TEST && hit) begin
          state_next = spf_pkg::ST_XING;
        end else if (adv) begin
          if (closing) begin
            state_next = spf_pkg::ST_EMIT;
          end else if (more) begin
            state_next = spf_pkg::ST_RD;
          end else begin
            state_next = spf_pkg::ST_TEST;
          end
        end
      end
      spf_pkg::ST_EMIT: begin
        if (npairs == '0 || (span_k + 1'b1) == npairs) begin
          state_next = spf_pkg::ST_IDLE;
        end
      end
      default: state_next = spf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ram_we  = accept && item.action == spf_pkg::ACT_ADD && !full;
    xstart  = (state == spf_pkg::ST_TEST) && hit;
    adv     = ((state == spf_pkg::ST_TEST) && !hit) ||
              ((state == spf_pkg::ST_XING) && xdone);
    ctl.clr = accept && item.action == spf_pkg::ACT_SCAN;
    ctl.ins = (state == spf_pkg::ST_XING) && xdone;
    ctl.shl = (state == spf_pkg::ST_EMIT) && npairs != '0;
  end

  // Assemble the result word for an accepted item or an emitted span
  always_comb begin
    result_next      = '0;
    result_next.last = 1'b1;
    if (state == spf_pkg::ST_EMIT) begin
      result_next.span_y    = line_y;
      result_next.fill_done = line_done;
      if (npairs != '0) begin
        result_next.span_x_start = cell_val[0];
        result_next.span_x_end   = cell_val[1];
        result_next.span_valid   = 1'b1;
        result_next.last         = (span_k + 1'b1) == npairs;
      end
    end else begin
      unique case (item.action)
        spf_pkg::ACT_ADD:  result_next.vertex_full = full;
        spf_pkg::ACT_SCAN: begin
          if (row_ok) begin
            result_next.span_y    = cl;
            result_next.fill_done = (cl_inc >= highest_y);
          end else begin
            result_next.fill_done = 1'b1;
          end
        end
        spf_pkg::ACT_CLEAR, spf_pkg::ACT_NONE: ;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= spf_pkg::ST_IDLE;
      vertex_count <= '0;
      lowest_y     <= '1;
      highest_y    <= '0;
      current_line <= '0;
      fill_started <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (accept && state_next == spf_pkg::ST_IDLE) ||
                (state == spf_pkg::ST_EMIT);
      if (accept) begin
        unique case (item.action)
          spf_pkg::ACT_ADD: begin
            if (!full) begin
              vertex_count <= vertex_count + 1'b1;
              if (item.vertex_y < lowest_y) lowest_y <= item.vertex_y;
              if (item.vertex_y > highest_y) highest_y <= item.vertex_y;
              fill_started <= 1'b0;
            end
          end
          spf_pkg::ACT_CLEAR: begin
            vertex_count <= '0;
            lowest_y     <= '1;
            highest_y    <= '0;
            current_line <= '0;
            fill_started <= 1'b0;
          end
          spf_pkg::ACT_SCAN: begin
            fill_started <= 1'b1;
            current_line <= row_ok ? cl_inc : cl;
          end
          spf_pkg::ACT_NONE: ;
          default: ;
        endcase
      end
    end
  end

  // Walk, count and result word registers
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
      if (item.action == spf_pkg::ACT_SCAN) begin
        idx       <= '0;
        closing   <= 1'b0;
        ncross    <= '0;
        span_k    <= '0;
        line_y    <= cl;
        line_done <= (cl_inc >= highest_y);
      end
    end else begin
      unique case (state)
        spf_pkg::ST_GET: begin
          prev <= rdata;
          if (idx == '0) begin
            first <= rdata;
            idx   <= IDX_W'(1);
          end else begin
            ea <= prev;
            eb <= rdata;
          end
        end
        spf_pkg::ST_TEST, spf_pkg::ST_XING: begin
          if (ctl.ins) begin
            ncross <= ncross + 1'b1;
          end
          if (adv && !closing) begin
            if (more) begin
              idx <= idx + 1'b1;
            end else begin
              // Close the polygon: last vertex back to the first
              closing <= 1'b1;
              ea      <= prev;
              eb      <= first;
            end
          end
        end
        spf_pkg::ST_EMIT: begin
          result <= result_next;
          if (npairs != '0) begin
            span_k <= span_k + 1'b1;
          end
        end
        spf_pkg::ST_IDLE, spf_pkg::ST_RD: ;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/spf_ram.sv =====
module spf_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/spf_xing.sv =====
module spf_xing (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [spf_pkg::COORD_BITS-1:0] ax,
  input  logic [spf_pkg::COORD_BITS-1:0] ay,
  input  logic [spf_pkg::COORD_BITS-1:0] bx,
  input  logic [spf_pkg::COORD_BITS-1:0] by,
  input  logic [spf_pkg::COORD_BITS-1:0] line_y,
  output logic                           done,
  output logic [spf_pkg::COORD_BITS-1:0] x
);

  localparam int CW    = spf_pkg::COORD_BITS;
  localparam int QW    = 2 * CW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CW:0]      dy;
  logic [CW:0]      dx;
  logic [CW:0]      den;
  logic [CW-1:0]    xbase;
  logic             mul_pend;
  logic             run;
  logic             fin;
  logic             neg;
  logic [CW-1:0]    dmag;
  logic [CW-1:0]    rem;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic [CW:0]      trial;
  logic [CW-1:0]    qlow;

  function automatic logic [CW-1:0] mag(input logic [CW:0] v);
    logic [CW:0] n;
    n = ~v + 1'b1;
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  assign trial = {rem, quo[QW-1]};
  assign qlow  = quo[CW-1:0];

  // Sequence: load differences, multiply, divide one bit a cycle, add base
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      run      <= 1'b0;
      fin      <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= fin && !start && !mul_pend && !run;
      if (start) begin
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        mul_pend <= 1'b0;
        run      <= 1'b1;
      end else if (run) begin
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dy    <= {1'b0, line_y} - {1'b0, ay};
      dx    <= {1'b0, bx} - {1'b0, ax};
      den   <= {1'b0, by} - {1'b0, ay};
      xbase <= ax;
    end else if (mul_pend) begin
      quo  <= mag(dy) * mag(dx);
      neg  <= dy[CW] ^ dx[CW] ^ den[CW];
      dmag <= mag(den);
      rem  <= '0;
      cnt  <= CNT_W'(QW);
    end else if (run) begin
      if (trial >= {1'b0, dmag}) begin
        rem <= CW'(trial - {1'b0, dmag});
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial[CW-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end else if (fin) begin
      // Quotient is truncated toward zero: negate the magnitude
      x <= neg ? (xbase - qlow) : (xbase + qlow);
    end
  end

endmodule

// ===== rtl/core/spf_cell.sv =====
module spf_cell #(
  parameter int W = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  spf_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]      new_val,
  input  logic [W-1:0]      left_val,
  input  logic              left_valid,
  input  logic              left_gt,
  input  logic [W-1:0]      far_val,
  input  logic              far_valid,
  output logic [W-1:0]      val,
  output logic              valid,
  output logic              gt
);

  // Empty cells count as larger than any word
  assign gt = !valid || (val > new_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins && gt) begin
      valid <= left_gt ? left_valid : 1'b1;
    end else if (ctl.shl) begin
      valid <= far_valid;
    end
  end

  // Insert: take the left neighbor or the new word; emit: advance by two
  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      val <= left_gt ? left_val : new_val;
    end else if (ctl.shl) begin
      val <= far_val;
    end
  end

endmodule
